### sv/stf_pkg.sv
// ----------------------------------------------------------------------------
// stf_pkg
// Shared types, character codes and digit helpers for the telemetry framer.
// ----------------------------------------------------------------------------
package stf_pkg;

  // Queue depth between the front pipeline and the character serializer
  localparam int STF_QUEUE_DEPTH = 4;

  // Frame geometry
  localparam int FRAME_LEN = 20;
  localparam int POS_W     = 5;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

  // ASCII codes used in the frame
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_OPEN  = 7'h28;
  localparam logic [6:0] CH_CLOSE = 7'h29;
  localparam logic [6:0] CH_COMMA = 7'h2C;
  localparam logic [6:0] CH_POINT = 7'h2E;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_CR    = 7'h0D;

  // Temperature conversion constants
  localparam logic [7:0]  TEMP_ZERO      = 8'd68;
  localparam logic [14:0] TEMP_POS_SCALE = 15'd150;
  localparam logic [14:0] TEMP_NEG_SCALE = 15'd55;
  localparam logic [7:0]  TEMP_NEG_BIAS  = 8'd55;
  // Reciprocals: x/187 = (x*22430)>>22 for x <= 28050, x/68 = (x*964)>>16 for x < 3740
  localparam logic [29:0] RECIP_187 = 30'd22430;
  localparam logic [29:0] RECIP_68  = 30'd964;
  // adc/51 = (adc*161)>>13 for adc <= 255
  localparam logic [15:0] RECIP_51  = 16'd161;
  localparam logic [7:0]  VOLT_DIV  = 8'd51;

  // One decoded frame: all digits in BCD plus the temperature sign
  typedef struct packed {
    logic [3:0]      volt_int;
    logic [3:0]      volt_d1;
    logic [3:0]      volt_d2;
    logic [2:0][3:0] cnt_dig;   // [2] hundreds, [1] tens, [0] ones
    logic            temp_neg;
    logic [2:0][3:0] temp_dig;  // [2] hundreds, [1] tens, [0] ones
  } stf_frame_t;

  // Quotient by ten for values below 100
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

  // Split an 8-bit value into hundreds, tens and ones
  function automatic logic [2:0][3:0] three_digits(input logic [7:0] v);
    logic [13:0]     ph;
    logic [1:0]      h;
    logic [6:0]      r;
    logic [3:0]      t;
    logic [2:0][3:0] d;
    ph   = 14'(v) * 14'd41;
    h    = ph[13:12];
    r    = 7'(v - 8'(h) * 8'd100);
    t    = div10(r);
    d[2] = {2'b00, h};
    d[1] = t;
    d[0] = 4'(r - 7'(t) * 7'd10);
    return d;
  endfunction

  // Digit to ASCII
  function automatic logic [6:0] to_ascii(input logic [3:0] d);
    return CH_ZERO + 7'(d);
  endfunction

endpackage

### sv/stf_front.sv
// ----------------------------------------------------------------------------
// stf_front
// Two-stage front pipeline: scales the readings and splits them into digits.
// ----------------------------------------------------------------------------
module stf_front
  import stf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] adc_code,
  input  logic [7:0] event_count,
  input  logic [7:0] temp_code,
  output logic       push,
  output stf_frame_t push_data,
  output logic [1:0] inflight
);

  // Stage 1 registers
  logic        v1;
  logic [7:0]  s1_adc;
  logic [7:0]  s1_cnt;
  logic        s1_neg;
  logic [14:0] s1_num;

  // Stage 2 registers
  logic        v2;
  logic [7:0]  s2_adc;
  logic [7:0]  s2_cnt;
  logic        s2_neg;
  logic [7:0]  s2_mag;
  logic [2:0]  s2_vi;

  logic        neg;
  logic [14:0] num;
  logic [29:0] p_pos;
  logic [29:0] p_neg;
  logic [15:0] p_adc;
  logic [7:0]  mag;
  logic [5:0]  vr;
  logic [3:0]  vd1;

  // Form the temperature numerator for either branch
  always_comb begin
    neg = (temp_code < TEMP_ZERO);
    if (neg) begin
      num = 15'(temp_code) * TEMP_NEG_SCALE;
    end else begin
      num = 15'(temp_code - TEMP_ZERO) * TEMP_POS_SCALE;
    end
  end

  // Divide by constants through reciprocal multiplies
  always_comb begin
    p_pos = 30'(s1_num) * RECIP_187;
    p_neg = 30'(s1_num) * RECIP_68;
    p_adc = 16'(s1_adc) * RECIP_51;
    if (s1_neg) begin
      mag = TEMP_NEG_BIAS - p_neg[23:16];
    end else begin
      mag = p_pos[29:22];
    end
  end

  // Split everything into BCD digits for the queue
  always_comb begin
    vr  = 6'(s2_adc - 8'(s2_vi) * VOLT_DIV);
    vd1 = div10(7'(vr));
    push_data.volt_int = 4'(s2_vi);
    push_data.volt_d1  = vd1;
    push_data.volt_d2  = 4'(vr - 6'(vd1) * 6'd10);
    push_data.cnt_dig  = three_digits(s2_cnt);
    push_data.temp_neg = s2_neg;
    push_data.temp_dig = three_digits(s2_mag);
  end

  assign push     = v2;
  assign inflight = {1'b0, v1} + {1'b0, v2};

  // Advance the pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  // Hold stage payloads
  always_ff @(posedge clk) begin
    s1_adc <= adc_code;
    s1_cnt <= event_count;
    s1_neg <= neg;
    s1_num <= num;
    s2_adc <= s1_adc;
    s2_cnt <= s1_cnt;
    s2_neg <= s1_neg;
    s2_mag <= mag;
    s2_vi  <= p_adc[15:13];
  end

endmodule

### sv/stf_queue.sv
// ----------------------------------------------------------------------------
// stf_queue
// Small register FIFO of decoded frames between front and serializer.
// ----------------------------------------------------------------------------
module stf_queue
  import stf_pkg::*;
#(
  parameter int DEPTH = STF_QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  stf_frame_t       push_data,
  input  logic             pop,
  output stf_frame_t       head,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  stf_frame_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Write the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### sv/stf_back.sv
// ----------------------------------------------------------------------------
// stf_back
// Character serializer: emits one frame character per cycle from a queued entry.
// ----------------------------------------------------------------------------
module stf_back
  import stf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stf_frame_t head,
  input  logic       empty,
  output logic       pop,
  output logic       strobe,
  output logic [6:0] ascii_char,
  output logic       frame_end
);

  stf_frame_t       cur;
  logic             active;
  logic [POS_W-1:0] idx;
  logic [6:0]       ch;

  // Load the next frame when idle or on the last character
  assign pop = !empty && (!active || (idx == POS_LAST));

  // Select the character at the current position
  always_comb begin
    case (idx)
      5'd0:    ch = CH_OPEN;
      5'd1:    ch = to_ascii(cur.volt_int);
      5'd2:    ch = CH_POINT;
      5'd3:    ch = to_ascii(cur.volt_d1);
      5'd4:    ch = to_ascii(cur.volt_d2);
      5'd5:    ch = CH_CLOSE;
      5'd6:    ch = CH_COMMA;
      5'd7:    ch = CH_OPEN;
      5'd8:    ch = to_ascii(cur.cnt_dig[2]);
      5'd9:    ch = to_ascii(cur.cnt_dig[1]);
      5'd10:   ch = to_ascii(cur.cnt_dig[0]);
      5'd11:   ch = CH_CLOSE;
      5'd12:   ch = CH_COMMA;
      5'd13:   ch = CH_OPEN;
      5'd14:   ch = cur.temp_neg ? CH_MINUS : CH_PLUS;
      5'd15:   ch = to_ascii(cur.temp_dig[2]);
      5'd16:   ch = to_ascii(cur.temp_dig[1]);
      5'd17:   ch = to_ascii(cur.temp_dig[0]);
      5'd18:   ch = CH_CLOSE;
      default: ch = CH_CR;
    endcase
  end

  // Advance the position and the output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active) begin
        if (idx == POS_LAST) begin
          active <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // Hold the frame and the output character
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    ascii_char <= ch;
    frame_end  <= (idx == POS_LAST);
  end

endmodule

### sv/sensor_telemetry_ascii_framer.sv
// ----------------------------------------------------------------------------
// sensor_telemetry_ascii_framer
// Turns each reading triple into the 20-character ASCII telemetry frame.
// ----------------------------------------------------------------------------
// A reading passes both front stages, the frame queue, the serializer's frame
// register and its output register before its first character is strobed.
// Characters of one frame leave on consecutive cycles; results cannot stall.
// Start is taken on consecutive cycles until the frame queue fills.
// Reset clears the pipeline valids, the queue and the serializer.
module sensor_telemetry_ascii_framer
  import stf_pkg::*;
#(
  parameter int QUEUE_DEPTH = STF_QUEUE_DEPTH,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] adc_code,
  input  logic [7:0] event_count,
  input  logic [7:0] temp_code,
  output logic       strobe,
  output logic [6:0] ascii_char,
  output logic       frame_end
);

  logic             accept;
  logic             push;
  stf_frame_t       push_data;
  logic [1:0]       inflight;
  stf_frame_t       head;
  logic             empty;
  logic             pop;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W:0]   occ;

  // Stall the input once queued plus in-flight transactions fill the queue
  assign occ    = {1'b0, q_count} + (CNT_W + 1)'(inflight);
  assign busy   = (occ >= (CNT_W + 1)'(QUEUE_DEPTH));
  assign accept = start && !busy;

  stf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .adc_code    (adc_code),
    .event_count (event_count),
    .temp_code   (temp_code),
    .push        (push),
    .push_data   (push_data),
    .inflight    (inflight)
  );

  stf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .count     (q_count)
  );

  stf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .frame_end  (frame_end)
  );

endmodule
